// File: design/rtwe_pkg.sv
package rtwe_pkg;

   // rate table and register rom sizes
   localparam int RATE_COUNT     = 13;
   localparam int RATE_REG_COUNT = 16;
   localparam int RATE_W         = $clog2(RATE_COUNT);
   localparam int ROW_W          = $clog2(RATE_REG_COUNT);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // operand carries a carrier offset (< 2^29), a prescaled spacing or a rate index
   localparam int OPND_W = 29;

   // setting kinds
   localparam logic [1:0] KIND_CARRIER = 2'd0;
   localparam logic [1:0] KIND_SPACING = 2'd1;
   localparam logic [1:0] KIND_RATE    = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_VALUE = 2'd1;
   localparam logic [1:0] ST_BAD_ADDR  = 2'd2;

   // carrier and spacing limits in Hz
   localparam logic [31:0] FREQ_MIN    = 32'd240000000;
   localparam logic [31:0] FREQ_MAX    = 32'd930000000;
   localparam logic [31:0] FREQ_SPLIT  = 32'd480000000;
   localparam logic [31:0] SPACING_MAX = 32'd2550000;
   localparam logic [22:0] HOP_ROUND   = 23'd5000;

   // reciprocal constants: x / 625 = (x * RECIP_625) >> 39 for x < 2^29
   localparam int          RECIP_SHIFT = 39;
   localparam logic [29:0] RECIP_625   = 30'd879609303;
   // spacing: y / 625 = (y * RECIP_HOP) >> 28 for y < 2^18
   localparam int          HOP_SHIFT   = 28;
   localparam logic [29:0] RECIP_HOP   = 30'd429497;
   // band: z / 125 = (z * RECIP_125) >> 20 for z < 2^13
   localparam int          BAND_SHIFT  = 20;
   localparam logic [13:0] RECIP_125   = 14'd8389;

   localparam logic [9:0]  DIV_625     = 10'd625;
   localparam logic [9:0]  ROUND_HALF  = 10'd313;
   localparam logic [19:0] STEPS_LOW   = 20'd16000;
   localparam logic [19:0] STEPS_HIGH  = 20'd32000;
   localparam logic [6:0]  BAND_HIGH   = 7'h20;
   localparam logic [6:0]  BAND_SIDE   = 7'h40;

   typedef enum logic [2:0] {
      OP_CAR_LOW   = 3'd0,
      OP_CAR_HIGH  = 3'd1,
      OP_HOP       = 3'd2,
      OP_RATE      = 3'd3,
      OP_BAD_VALUE = 3'd4,
      OP_BAD_ADDR  = 3'd5
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [OPND_W-1:0]   operand;
   } cmd_type;

   localparam logic [31:0] RATE_LIST [RATE_COUNT] = '{
      32'd500, 32'd1000, 32'd2000, 32'd4000, 32'd8000, 32'd9600, 32'd16000,
      32'd19200, 32'd24000, 32'd32000, 32'd64000, 32'd128000, 32'd192000
   };

   localparam logic [7:0] ROM_ADDR [RATE_REG_COUNT] = '{
      8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
      8'h24, 8'h25, 8'h2A, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72
   };

   localparam logic [7:0] ROM_DATA [RATE_REG_COUNT][RATE_COUNT] = '{
      '{8'h37,8'h37,8'h37,8'h37,8'h3A,8'h3B,8'h26,8'h28,8'h2E,8'h16,8'h07,8'h83,8'h8A},
      '{8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44},
      '{8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A},
      '{8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03},
      '{8'hE8,8'hF4,8'hFA,8'h70,8'h3F,8'h34,8'h3F,8'h34,8'h2A,8'h3F,8'h3F,8'h5E,8'h3F},
      '{8'h60,8'h20,8'h00,8'h01,8'h02,8'h02,8'h02,8'h02,8'h03,8'h02,8'h02,8'h01,8'h02},
      '{8'h20,8'h41,8'h83,8'h06,8'h0C,8'h75,8'h0C,8'h75,8'h12,8'h0C,8'h0C,8'h5D,8'h0C},
      '{8'hC5,8'h89,8'h12,8'h25,8'h4A,8'h25,8'h4A,8'h25,8'h6F,8'h4A,8'h4A,8'h86,8'h4A},
      '{8'h00,8'h00,8'h00,8'h02,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h05,8'h07},
      '{8'h0A,8'h23,8'h85,8'h0E,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h74,8'hFF},
      '{8'h0E,8'h0E,8'h0E,8'h0E,8'h0E,8'h0D,8'h0D,8'h0E,8'h12,8'h17,8'h31,8'h50,8'h50},
      '{8'h04,8'h08,8'h10,8'h20,8'h41,8'h4E,8'h83,8'h9D,8'hC4,8'h08,8'h10,8'h20,8'h31},
      '{8'h19,8'h31,8'h62,8'hC5,8'h89,8'hA5,8'h12,8'h49,8'h9C,8'h31,8'h62,8'hC5,8'h27},
      '{8'h2D,8'h2D,8'h2D,8'h2D,8'h2D,8'h2D,8'h2D,8'h2D,8'h2D,8'h0D,8'h0D,8'h0D,8'h0D},
      '{8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23},
      '{8'h06,8'h06,8'h06,8'h06,8'h06,8'h08,8'h0D,8'h0F,8'h13,8'h1A,8'h33,8'h66,8'h9A}
   };

endpackage

// File: design/radio_tuning_word_encoder.sv
// back end path per req word: errors S_IDLE, S_EMIT; spacing S_IDLE, S_MUL, S_EMIT;
//   carrier S_IDLE, S_MUL, S_SPLIT, S_MULB, S_BAND, S_EMIT; air rate S_IDLE, S_RATE
//   (16 pairs, one per cycle unless stalled); one req word at a time in the sequencer
// a four deep command queue lets req words keep arriving while the back end works
// reset: synchronous, active high; clears the queue, the sequencer and rsp_valid
module radio_tuning_word_encoder
   import rtwe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_band_select,
   output logic [15:0] rsp_carrier_word,
   output logic [7:0]  rsp_hop_step,
   output logic [7:0]  rsp_reg_addr,
   output logic [7:0]  rsp_reg_data,
   output logic        rsp_last
);

   // front to queue
   cmd_type push_cmd;
   logic    q_push;
   logic    q_full;

   // queue to back end
   cmd_type pop_cmd;
   logic    q_pop;
   logic    q_empty;

   // front: range checks, band choice, rate table search
   rtwe_front u_front (
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_value (req_value),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   // short command queue decouples the two sides
   rtwe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   // back end: reciprocal divides, rounding, rom walk and the rsp register
   rtwe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_cmd            (pop_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_band_select  (rsp_band_select),
      .rsp_carrier_word (rsp_carrier_word),
      .rsp_hop_step     (rsp_hop_step),
      .rsp_reg_addr     (rsp_reg_addr),
      .rsp_reg_data     (rsp_reg_data),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   // an error word is always the only word of its request
   a_err_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_last)
      else $error("error word without last");

   // a band word only comes with success and the sideband bit
   a_band_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_band_select != 7'd0) |->
      (rsp_status == ST_OK) && rsp_band_select[6])
      else $error("band select on a non carrier word");

   // rom pairs stream without gaps once the receiver takes them
   a_rate_stream : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a register pair burst");
`endif

endmodule

// File: design/rtwe_front.sv
module rtwe_front
   import rtwe_pkg::*;
(
   input  logic        req_valid,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_value,
   output logic        req_stall,
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   logic [RATE_W-1:0] rate_sel;
   logic [22:0]       hop_sum;

   // first table rate at or above the request, else the last rate
   always_comb begin
      rate_sel = RATE_W'(RATE_COUNT - 1);
      for (int i = RATE_COUNT - 2; i >= 0; i--) begin
         if (RATE_LIST[i] >= req_value) begin
            rate_sel = RATE_W'(i);
         end
      end
   end

   assign hop_sum = {1'b0, req_value[21:0]} + HOP_ROUND;

   always_comb begin
      q_cmd.op      = OP_BAD_ADDR;
      q_cmd.operand = '0;
      unique case (req_kind)
         KIND_CARRIER: begin
            if (req_value < FREQ_MIN || req_value > FREQ_MAX) begin
               q_cmd.op = OP_BAD_VALUE;
            end else if (req_value > FREQ_SPLIT) begin
               q_cmd.op      = OP_CAR_HIGH;
               q_cmd.operand = OPND_W'(req_value - FREQ_SPLIT);
            end else begin
               q_cmd.op      = OP_CAR_LOW;
               q_cmd.operand = OPND_W'(req_value - FREQ_MIN);
            end
         end
         KIND_SPACING: begin
            if (req_value > SPACING_MAX) begin
               q_cmd.op = OP_BAD_VALUE;
            end else begin
               // divide by 16 here, the back end divides by 625
               q_cmd.op      = OP_HOP;
               q_cmd.operand = OPND_W'(hop_sum[22:4]);
            end
         end
         KIND_RATE: begin
            q_cmd.op      = OP_RATE;
            q_cmd.operand = OPND_W'(rate_sel);
         end
         default: begin
            q_cmd.op = OP_BAD_ADDR;
         end
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// File: design/rtwe_queue.sv
module rtwe_queue
   import rtwe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: design/rtwe_back.sv
module rtwe_back
   import rtwe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_band_select,
   output logic [15:0] rsp_carrier_word,
   output logic [7:0]  rsp_hop_step,
   output logic [7:0]  rsp_reg_addr,
   output logic [7:0]  rsp_reg_data,
   output logic        rsp_last
);

   localparam int PROD_W = OPND_W + 30;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MUL   = 7'b0000010,
      S_SPLIT = 7'b0000100,
      S_MULB  = 7'b0001000,
      S_BAND  = 7'b0010000,
      S_EMIT  = 7'b0100000,
      S_RATE  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [19:0]        f_ff, f_in;
   logic [29:0]        fr_ff, fr_in;
   logic [26:0]        qp_ff, qp_in;
   logic [4:0]         band_ff, band_in;
   logic [19:0]        bm_ff, bm_in;
   logic               round_ff, round_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [6:0]         rsp_band_ff, rsp_band_in;
   logic [15:0]        rsp_carrier_ff, rsp_carrier_in;
   logic [7:0]         rsp_hop_ff, rsp_hop_in;
   logic [7:0]         rsp_addr_ff, rsp_addr_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               high;
   logic [12:0]        band_num;
   logic [28:0]        rem;
   logic [19:0]        word_q;
   logic [RATE_W-1:0]  sel;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign high     = (cmd_ff.op == OP_CAR_HIGH);
   assign band_num = high ? {1'b0, f_ff[19:8]} : f_ff[19:7];
   assign rem      = cmd_ff.operand - fr_ff[28:0];
   assign word_q   = f_ff - bm_ff + 20'(round_ff);
   assign sel      = cmd_ff.operand[RATE_W-1:0];
   assign q_pop    = (state_ff == S_IDLE) && !q_empty;

   // arithmetic datapath, one multiplier level per state
   always_comb begin
      prod_in  = PROD_W'(cmd_ff.operand) *
                 PROD_W'((cmd_ff.op == OP_HOP) ? RECIP_HOP : RECIP_625);
      f_in     = prod_ff[RECIP_SHIFT +: 20];
      fr_in    = 30'(f_ff) * 30'(DIV_625);
      qp_in    = 27'(band_num) * 27'(RECIP_125);
      band_in  = qp_ff[BAND_SHIFT +: 5];
      bm_in    = 20'(qp_ff[BAND_SHIFT +: 5]) * (high ? STEPS_HIGH : STEPS_LOW);
      round_in = (rem[9:0] >= ROUND_HALF);
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      row_in         = row_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_band_in    = rsp_band_ff;
      rsp_carrier_in = rsp_carrier_ff;
      rsp_hop_in     = rsp_hop_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               cmd_in = q_cmd;
               row_in = '0;
               case (q_cmd.op) inside
                  OP_CAR_LOW, OP_CAR_HIGH, OP_HOP: state_in = S_MUL;
                  OP_RATE:                         state_in = S_RATE;
                  default:                         state_in = S_EMIT;
               endcase
            end
         end
         S_MUL: begin
            state_in = (cmd_ff.op == OP_HOP) ? S_EMIT : S_SPLIT;
         end
         S_SPLIT: state_in = S_MULB;
         S_MULB:  state_in = S_BAND;
         S_BAND:  state_in = S_EMIT;
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_band_in    = '0;
               rsp_carrier_in = '0;
               rsp_hop_in     = '0;
               rsp_addr_in    = '0;
               rsp_data_in    = '0;
               rsp_last_in    = 1'b1;
               case (cmd_ff.op)
                  OP_CAR_LOW: begin
                     rsp_band_in    = BAND_SIDE | 7'(band_ff);
                     rsp_carrier_in = {word_q[13:0], 2'b00};
                  end
                  OP_CAR_HIGH: begin
                     rsp_band_in    = BAND_SIDE | BAND_HIGH | 7'(band_ff);
                     rsp_carrier_in = {word_q[14:0], 1'b0};
                  end
                  OP_HOP:       rsp_hop_in    = prod_ff[HOP_SHIFT +: 8];
                  OP_BAD_VALUE: rsp_status_in = ST_BAD_VALUE;
                  default:      rsp_status_in = ST_BAD_ADDR;
               endcase
               state_in = S_IDLE;
            end
         end
         S_RATE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_band_in    = '0;
               rsp_carrier_in = '0;
               rsp_hop_in     = '0;
               rsp_addr_in    = ROM_ADDR[row_ff];
               rsp_data_in    = ROM_DATA[row_ff][sel];
               rsp_last_in    = (row_ff == ROW_W'(RATE_REG_COUNT - 1));
               row_in         = row_ff + 1'b1;
               if (row_ff == ROW_W'(RATE_REG_COUNT - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      row_ff         <= row_in;
      prod_ff        <= prod_in;
      f_ff           <= f_in;
      fr_ff          <= fr_in;
      qp_ff          <= qp_in;
      band_ff        <= band_in;
      bm_ff          <= bm_in;
      round_ff       <= round_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_band_ff    <= rsp_band_in;
      rsp_carrier_ff <= rsp_carrier_in;
      rsp_hop_ff     <= rsp_hop_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_band_select  = rsp_band_ff;
   assign rsp_carrier_word = rsp_carrier_ff;
   assign rsp_hop_step     = rsp_hop_ff;
   assign rsp_reg_addr     = rsp_addr_ff;
   assign rsp_reg_data     = rsp_data_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import rtwe_pkg::*;

   // kind with no setting behind it
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // carrier and spacing limits and steps in Hz, band flag bits
   localparam logic [31:0] CARRIER_MIN_HZ  = 32'd240000000;
   localparam logic [31:0] CARRIER_MAX_HZ  = 32'd930000000;
   localparam logic [31:0] CARRIER_MID_HZ  = 32'd480000000;
   localparam logic [31:0] HIGH_STEP_HZ    = 32'd20000000;
   localparam logic [31:0] LOW_STEP_HZ     = 32'd10000000;
   localparam logic [31:0] SPACING_MAX_HZ  = 32'd2550000;
   localparam logic [31:0] HOP_UNIT_HZ     = 32'd10000;
   localparam logic [31:0] FINE_UNIT       = 32'd625;
   localparam logic [6:0]  BAND_FLAG_HIGH  = 7'h20;
   localparam logic [6:0]  BAND_FLAG_SIDE  = 7'h40;

   // run control
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 200;
   localparam int DRAIN_CYCLES   = 20;

   // air rates and the register rom they select
   localparam logic [31:0] AIR_RATES [RATE_COUNT] = '{
      32'd500, 32'd1000, 32'd2000, 32'd4000, 32'd8000, 32'd9600, 32'd16000,
      32'd19200, 32'd24000, 32'd32000, 32'd64000, 32'd128000, 32'd192000
   };

   localparam logic [7:0] RATE_REG_ADDR [RATE_REG_COUNT] = '{
      8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
      8'h24, 8'h25, 8'h2A, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72
   };

   localparam logic [7:0] RATE_REG_DATA [RATE_REG_COUNT][RATE_COUNT] = '{
      '{8'h37,8'h37,8'h37,8'h37,8'h3A,8'h3B,8'h26,8'h28,8'h2E,8'h16,8'h07,8'h83,8'h8A},
      '{8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44,8'h44},
      '{8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A},
      '{8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03},
      '{8'hE8,8'hF4,8'hFA,8'h70,8'h3F,8'h34,8'h3F,8'h34,8'h2A,8'h3F,8'h3F,8'h5E,8'h3F},
      '{8'h60,8'h20,8'h00,8'h01,8'h02,8'h02,8'h02,8'h02,8'h03,8'h02,8'h02,8'h01,8'h02},
      '{8'h20,8'h41,8'h83,8'h06,8'h0C,8'h75,8'h0C,8'h75,8'h12,8'h0C,8'h0C,8'h5D,8'h0C},
      '{8'hC5,8'h89,8'h12,8'h25,8'h4A,8'h25,8'h4A,8'h25,8'h6F,8'h4A,8'h4A,8'h86,8'h4A},
      '{8'h00,8'h00,8'h00,8'h02,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h05,8'h07},
      '{8'h0A,8'h23,8'h85,8'h0E,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h74,8'hFF},
      '{8'h0E,8'h0E,8'h0E,8'h0E,8'h0E,8'h0D,8'h0D,8'h0E,8'h12,8'h17,8'h31,8'h50,8'h50},
      '{8'h04,8'h08,8'h10,8'h20,8'h41,8'h4E,8'h83,8'h9D,8'hC4,8'h08,8'h10,8'h20,8'h31},
      '{8'h19,8'h31,8'h62,8'hC5,8'h89,8'hA5,8'h12,8'h49,8'h9C,8'h31,8'h62,8'hC5,8'h27},
      '{8'h2D,8'h2D,8'h2D,8'h2D,8'h2D,8'h2D,8'h2D,8'h2D,8'h2D,8'h0D,8'h0D,8'h0D,8'h0D},
      '{8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23},
      '{8'h06,8'h06,8'h06,8'h06,8'h06,8'h08,8'h0D,8'h0F,8'h13,8'h1A,8'h33,8'h66,8'h9A}
   };

   // directed settings: band edges, rounding corners, rate table ends, bad kind
   localparam int DIRECTED_COUNT = 25;
   localparam logic [1:0] DIRECTED_KIND [DIRECTED_COUNT] = '{
      KIND_CARRIER, KIND_CARRIER, KIND_CARRIER, KIND_CARRIER, KIND_CARRIER,
      KIND_CARRIER, KIND_CARRIER, KIND_CARRIER, KIND_CARRIER, KIND_CARRIER,
      KIND_CARRIER, KIND_SPACING, KIND_SPACING, KIND_SPACING, KIND_SPACING,
      KIND_SPACING, KIND_SPACING, KIND_RATE, KIND_RATE, KIND_RATE,
      KIND_RATE, KIND_RATE, KIND_RATE, KIND_UNUSED, KIND_UNUSED
   };
   localparam logic [31:0] DIRECTED_VALUE [DIRECTED_COUNT] = '{
      32'd0, 32'd239999999, 32'd240000000, 32'd240000312, 32'd249999999,
      32'd480000000, 32'd480000001, 32'd499999999, 32'd930000000, 32'd930000001,
      32'hFFFFFFFF, 32'd0, 32'd4999, 32'd5000, 32'd2550000,
      32'd2550001, 32'hFFFFFFFF, 32'd0, 32'd9600, 32'd9601,
      32'd192000, 32'd192001, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF
   };

   // one result word, field order as on the rsp_ ports
   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  band_select;
      logic [15:0] carrier_word;
      logic [7:0]  hop_step;
      logic [7:0]  reg_addr;
      logic [7:0]  reg_data;
      logic        last;
   } tuning_word_type;

   // encodes each accepted setting into the words the block owes, checks them in order
   class tuning_word_board;
      tuning_word_type due_words[$];
      int failures;

      function new();
         failures = 0;
      endfunction

      function void note_setting(input logic [1:0] kind, input logic [31:0] value);
         tuning_word_type w;
         logic [31:0] offset;
         logic [31:0] band;
         int sel;
         w = '0;
         w.last = 1'b1;
         case (kind)
            KIND_CARRIER: begin
               if (value < CARRIER_MIN_HZ || value > CARRIER_MAX_HZ) begin
                  w.status = ST_BAD_VALUE;
               end else if (value > CARRIER_MID_HZ) begin
                  // high band: 20 MHz bands above 480 MHz, fine word shifted by 1
                  offset = value - CARRIER_MID_HZ;
                  band = offset / HIGH_STEP_HZ;
                  offset = offset - band * HIGH_STEP_HZ;
                  w.status = ST_OK;
                  w.carrier_word = 16'(((offset + (FINE_UNIT >> 1)) / FINE_UNIT) << 1);
                  w.band_select = 7'(band) | BAND_FLAG_HIGH | BAND_FLAG_SIDE;
               end else begin
                  // low band: 10 MHz bands above 240 MHz, fine word shifted by 2
                  offset = value - CARRIER_MIN_HZ;
                  band = offset / LOW_STEP_HZ;
                  offset = offset - band * LOW_STEP_HZ;
                  w.status = ST_OK;
                  w.carrier_word = 16'(((offset + (FINE_UNIT >> 1)) / FINE_UNIT) << 2);
                  w.band_select = 7'(band) | BAND_FLAG_SIDE;
               end
               due_words.push_back(w);
            end
            KIND_SPACING: begin
               if (value > SPACING_MAX_HZ) begin
                  w.status = ST_BAD_VALUE;
               end else begin
                  w.status = ST_OK;
                  w.hop_step = 8'((value + (HOP_UNIT_HZ >> 1)) / HOP_UNIT_HZ);
               end
               due_words.push_back(w);
            end
            KIND_RATE: begin
               // lowest table rate that covers the request, else the top rate
               sel = RATE_COUNT - 1;
               for (int i = RATE_COUNT - 2; i >= 0; i--) begin
                  if (AIR_RATES[i] >= value) sel = i;
               end
               for (int row = 0; row < RATE_REG_COUNT; row++) begin
                  w = '0;
                  w.status = ST_OK;
                  w.reg_addr = RATE_REG_ADDR[row];
                  w.reg_data = RATE_REG_DATA[row][sel];
                  w.last = (row == RATE_REG_COUNT - 1);
                  due_words.push_back(w);
               end
            end
            default: begin
               w.status = ST_BAD_ADDR;
               due_words.push_back(w);
            end
         endcase
      endfunction

      function bit field_ok(input string name, input logic [31:0] want,
                            input logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_word(input tuning_word_type got);
         tuning_word_type want;
         bit ok;
         if (due_words.size() == 0) begin
            $error("result word with nothing outstanding: 0x%0h", got);
            failures++;
            return;
         end
         want = due_words.pop_front();
         ok = 1'b1;
         ok &= field_ok("status", want.status, got.status);
         ok &= field_ok("band_select", want.band_select, got.band_select);
         ok &= field_ok("carrier_word", want.carrier_word, got.carrier_word);
         ok &= field_ok("hop_step", want.hop_step, got.hop_step);
         ok &= field_ok("reg_addr", want.reg_addr, got.reg_addr);
         ok &= field_ok("reg_data", want.reg_data, got.reg_data);
         ok &= field_ok("last", want.last, got.last);
         if (!ok) failures++;
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_band_select;
   logic [15:0] rsp_carrier_word;
   logic [7:0]  rsp_hop_step;
   logic [7:0]  rsp_reg_addr;
   logic [7:0]  rsp_reg_data;
   logic        rsp_last;

   tuning_word_board board;

   // idle odds in percent per cycle, changed between phases
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   // raised by the stimulus to make the receiver hold off for a long stretch
   bit hold_request = 1'b0;

   radio_tuning_word_encoder dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one setting word, idling first at the current odds, wait for acceptance
   task automatic send_word(input logic [1:0] kind, input logic [31:0] value);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_setting(kind, value);
   endtask

   // mostly legal settings with random content, some out of range values and bad kinds
   task automatic pick_setting(output logic [1:0] kind, output logic [31:0] value);
      int roll;
      roll = $urandom_range(99);
      if (roll < 35) begin
         kind = KIND_CARRIER;
         value = ($urandom_range(9) < 8) ? $urandom_range(CARRIER_MAX_HZ, CARRIER_MIN_HZ)
                                         : $urandom();
      end else if (roll < 60) begin
         kind = KIND_SPACING;
         value = ($urandom_range(9) < 8) ? $urandom_range(SPACING_MAX_HZ, 0) : $urandom();
      end else if (roll < 88) begin
         kind = KIND_RATE;
         case ($urandom_range(3))
            0: value = AIR_RATES[$urandom_range(RATE_COUNT - 1)];
            1: value = AIR_RATES[$urandom_range(RATE_COUNT - 1)] + $urandom_range(2) - 1;
            2: value = $urandom_range(200000);
            default: value = $urandom();
         endcase
      end else begin
         kind = KIND_UNUSED;
         value = $urandom();
      end
   endtask

   task automatic run_random(input int count);
      logic [1:0] kind;
      logic [31:0] value;
      repeat (count) begin
         pick_setting(kind, value);
         send_word(kind, value);
      end
   endtask

   // stop offering and wait for every owed word to come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.due_words.size() != 0) @(posedge clock);
   endtask

   // receiver: check accepted words, then pick the stall for the next cycle
   initial begin
      int hold_left;
      tuning_word_type got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_band_select, rsp_carrier_word, rsp_hop_step,
                   rsp_reg_addr, rsp_reg_data, rsp_last};
            board.check_word(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (rsp_idle_pct > 0 && $urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // watchdog: too many cycles without a word moving on either side
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("testbench failed");
      $finish;
   end

   initial begin
      board = new();
      // phase one: sender idles a little, receiver a lot
      send_idle_pct = 27;
      rsp_idle_pct = 70;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) send_word(DIRECTED_KIND[i], DIRECTED_VALUE[i]);
      run_random(30);

      // receiver holds off while the sender keeps going, so the queue fills
      hold_request = 1'b1;
      run_random(10);
      wait_drained();

      // phase two: roles swapped
      send_idle_pct = 70;
      rsp_idle_pct = 27;
      run_random(30);
      wait_drained();

      // phase three: back to back, with one more long hold-off
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(25);
      hold_request = 1'b1;
      run_random(10);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.due_words.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/rtwe_pkg.sv
design/rtwe_front.sv
design/rtwe_queue.sv
design/rtwe_back.sv
design/radio_tuning_word_encoder.sv
verif/testbench.sv
